// ===== design/base32_stream_encoder_defines.svh =====
// Assertion macros shared by the base32 stream encoder modules.
// Depends on nothing; the asserting module must have aclk and aresetn.
`ifndef BASE32_STREAM_ENCODER_DEFINES_SVH
`define BASE32_STREAM_ENCODER_DEFINES_SVH

// Checked at every clock edge, reset included.
`define B32E_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

// Checked only while the block is out of reset.
`define B32E_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

// ===== design/b32e_pkg.sv =====
// Package of the base32 stream encoder: queue entry type, sizes and character tables.
// Used by every module of the encoder; depends on nothing.
package b32e_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW = $clog2(QDepth);
    localparam int QCntW = QPtrW + 1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [2:0] GROUP_LAST = 3'd4;

    typedef struct packed {
        logic [4:0] slice0;
        logic [4:0] slice1;
        logic [4:0] slice2;
        logic [1:0] ncode;
        logic [2:0] npad;
        logic       last;
    } b32e_entry_t;

    function automatic logic [7:0] b32e_alphabet(input logic [4:0] idx);
        logic [7:0] code;
        if (idx < 5'd26) begin
            code = 8'h41 + {3'b000, idx};
        end else begin
            code = 8'h32 + {3'b000, idx - 5'd26};
        end
        return code;
    endfunction

    function automatic logic [2:0] b32e_pads(input logic [2:0] group_pos);
        logic [2:0] pads;
        unique case (group_pos)
            3'd1:    pads = 3'd6;
            3'd2:    pads = 3'd4;
            3'd3:    pads = 3'd3;
            3'd4:    pads = 3'd1;
            default: pads = 3'd0;
        endcase
        return pads;
    endfunction

endpackage

// ===== design/b32e_front.sv =====
// Front end of the base32 stream encoder: accepts bytes, slices them into 5-bit codes.
// Holds the leftover bits and group position; depends on b32e_pkg.
module b32e_front import b32e_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_in_last,
    input  logic        q_full,
    output logic        q_push,
    output b32e_entry_t q_entry
);

    logic [3:0]  lbits_reg, lbits_next;
    logic [2:0]  lcnt_reg, lcnt_next;
    logic [2:0]  gpos_reg, gpos_next;
    logic [11:0] acc;
    logic [3:0]  total;
    logic        two;
    logic [2:0]  new_cnt;
    logic [11:0] mask;
    logic [3:0]  new_bits;
    logic [8:0]  flush_wide;
    logic [4:0]  slice0, slice1, flush;
    logic [2:0]  gpos_inc;
    logic [11:0] sh0, sh1;

    assign s_ready = !q_full;
    assign q_push = s_valid && s_ready;

    always_comb begin
        acc = {lbits_reg, s_data_byte};
        total = {1'b0, lcnt_reg} + 4'd8;
        two = (total >= 4'd10);
        sh0 = acc >> (total - 4'd5);
        sh1 = acc >> (total - 4'd10);
        slice0 = sh0[4:0];
        slice1 = sh1[4:0];
        new_cnt = two ? 3'(total - 4'd10) : 3'(total - 4'd5);
        mask = (12'd1 << new_cnt) - 12'd1;
        new_bits = 4'(acc & mask);
        flush_wide = {5'b00000, new_bits} << (3'd5 - new_cnt);
        flush = flush_wide[4:0];
        gpos_inc = (gpos_reg == GROUP_LAST) ? 3'd0 : gpos_reg + 3'd1;

        q_entry.slice0 = slice0;
        q_entry.slice1 = two ? slice1 : flush;
        q_entry.slice2 = flush;
        q_entry.ncode = two ? 2'd2 : 2'd1;
        q_entry.npad = 3'd0;
        q_entry.last = s_in_last;
        if (s_in_last) begin
            if (new_cnt != 3'd0) begin
                q_entry.ncode = two ? 2'd3 : 2'd2;
            end
            q_entry.npad = b32e_pads(gpos_inc);
        end

        lbits_next = lbits_reg;
        lcnt_next = lcnt_reg;
        gpos_next = gpos_reg;
        if (q_push) begin
            if (s_in_last) begin
                lbits_next = 4'd0;
                lcnt_next = 3'd0;
                gpos_next = 3'd0;
            end else begin
                lbits_next = new_bits;
                lcnt_next = new_cnt;
                gpos_next = gpos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lbits_reg <= 4'd0;
            lcnt_reg <= 3'd0;
            gpos_reg <= 3'd0;
        end else begin
            lbits_reg <= lbits_next;
            lcnt_reg <= lcnt_next;
            gpos_reg <= gpos_next;
        end
    end

endmodule

// ===== design/b32e_queue.sv =====
// Short queue of sliced transactions between the front and back of the encoder.
// Depends on b32e_pkg and the assertion macros header.
`include "base32_stream_encoder_defines.svh"
module b32e_queue import b32e_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  b32e_entry_t push_entry,
    input  logic        pop,
    output b32e_entry_t head_entry,
    output logic        full,
    output logic        empty
);

    b32e_entry_t      mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    assign full = (count_reg == QCntW'(QDepth));
    assign empty = (count_reg == '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPtrW'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    `B32E_ASSERT(a_count_bound, !aresetn || (count_reg <= QCntW'(QDepth)), "queue count above depth")
    `B32E_ASSERT_RST(a_no_overrun, !(push && full) && !(pop && empty),
        "queue pushed while full or popped while empty")

endmodule

// ===== design/b32e_back.sv =====
// Back end of the base32 stream encoder: one character per cycle from queued slices while
// m_ready allows. Drives the output register; depends on b32e_pkg and assertion macros header.
`include "base32_stream_encoder_defines.svh"
module b32e_back import b32e_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  b32e_entry_t head_entry,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_out_last
);

    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic [3:0] total;
    logic       emit;
    logic       final_char;
    logic [4:0] slice_sel;

    assign m_valid = m_valid_reg;
    assign m_out_char = char_reg;
    assign m_out_last = last_reg;

    always_comb begin
        total = {2'b00, head_entry.ncode} + {1'b0, head_entry.npad};
        emit = !q_empty && (!m_valid_reg || m_ready);
        final_char = ({1'b0, idx_reg} == total - 4'd1);
        q_pop = emit && final_char;

        case (idx_reg)
            3'd0:    slice_sel = head_entry.slice0;
            3'd1:    slice_sel = head_entry.slice1;
            default: slice_sel = head_entry.slice2;
        endcase

        idx_next = idx_reg;
        m_valid_next = m_valid_reg;
        char_next = char_reg;
        last_next = last_reg;
        if (emit) begin
            idx_next = final_char ? 3'd0 : idx_reg + 3'd1;
            m_valid_next = 1'b1;
            char_next = (idx_reg < {1'b0, head_entry.ncode}) ? b32e_alphabet(slice_sel)
                                                             : PAD_CHAR;
            last_next = final_char && head_entry.last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    `B32E_ASSERT_RST(a_idx_in_entry, !q_empty |-> ({1'b0, idx_reg} < total),
        "character index beyond the current transaction")
    `B32E_ASSERT_RST(a_idx_idle, q_empty |-> (idx_reg == 3'd0),
        "character index not cleared while queue is empty")
    `B32E_ASSERT_RST(a_idx_restart, q_pop |=> (idx_reg == 3'd0),
        "character index not restarted after a transaction completed")

endmodule

// ===== design/base32_stream_encoder.sv =====
// Path: an accepted byte enters the queue, which takes new bytes while not full, then its
// characters go to the output register. Throughput: one character per cycle while m_ready
// is high and the queue is not empty; a byte yields 1 to 2 characters, a final byte up to 8,
// about 1.6 characters per byte sustained. Reset: synchronous, active-low aresetn clears
// leftover bits, group position, queue and output valid; it is ready once reset is released.
module base32_stream_encoder import b32e_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_out_last
);

    b32e_entry_t push_entry;
    b32e_entry_t head_entry;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;

    b32e_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_in_last   (s_in_last),
        .q_full      (full),
        .q_push      (push),
        .q_entry     (push_entry)
    );

    b32e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .full       (full),
        .empty      (empty)
    );

    b32e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_empty    (empty),
        .q_pop      (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_out_last (m_out_last)
    );

endmodule
